### sv/ffsa_pkg.sv
// Package for the first-fit segment allocator: request and status codes,
// result record type, saturating add. No dependencies.
package ffsa_pkg;
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_FND  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_BAD_IDX  = 3'd4;

    localparam logic [31:0] LEN_MAX    = 32'hFFFF_FFFF;
    localparam logic [31:0] CAP_RESET  = 32'd1048576;

    typedef struct packed {
        logic [2:0]  status;
        logic        rd_free;
        logic [15:0] rd_id;
        logic [31:0] rd_size;
        logic [6:0]  seg_total;
        logic        full_flag;
    } t_result;

    // 32-bit saturating add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? LEN_MAX : s[31:0];
    endfunction
endpackage

### sv/first_fit_segment_allocator.sv
// First-fit segment allocator top level: sequencer, segment table memory.
// Depends on ffsa_pkg.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata: req_type,file_id,size_kb,seg_index
//  m_axis  | out | tvalid/tready        | tdata: status,rd_free,rd_id,rd_size,seg_total,full
//  cfg     | in  | i_cfg_valid/o_cfg_ready | capacity_kb
//
// One item at a time; each step reads one entry through one port and writes
// at most one entry. A capacity write sets the table to one free segment; after
// reset a boot cycle writes entry 0. The next item is taken once the result
// register is empty; a pending capacity write goes first and is taken only
// with no result waiting.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ID_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type, [17:2] file_id, [49:18] size_kb, [55:50] seg_index
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] rd_free, [19:4] rd_id, [51:20] rd_size,
    // [58:52] seg_total, [59] full_flag, [63:60] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import ffsa_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int RW = 1 + ID_BITS + 32;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;  // insert search
    localparam logic [3:0] S_SHIFT  = 4'd2;  // open a hole at r_pos
    localparam logic [3:0] S_PLACE  = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;  // compact pass
    localparam logic [3:0] S_CTAIL  = 4'd5;
    localparam logic [3:0] S_RFIND  = 4'd6;  // remove search
    localparam logic [3:0] S_RMRG   = 4'd7;  // merge decisions
    localparam logic [3:0] S_DEL    = 4'd8;  // close a hole at r_i
    localparam logic [3:0] S_READ   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_RDEL2  = 4'd11;

    // table memory: {free, owner, length}
    logic [RW-1:0] r_mem [MAX_SEGMENTS];
    logic [RW-1:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;
    logic          wr_en;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_full, n_full;
    logic          r_boot;
    logic [CW-1:0] r_i, n_i;       // scan index
    logic [CW-1:0] r_w, n_w;       // compact write index / aux
    logic [AW-1:0] r_pos, n_pos;
    logic          r_rv, n_rv;     // r_rd holds entry at r_i-1 (valid pipeline)
    logic [31:0]   r_acc, n_acc;
    logic          r_any, n_any;
    logic          r_retry, n_retry;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_req;
    logic [ID_BITS-1:0] r_id;
    logic [31:0]   r_size;
    logic [5:0]    r_idx;
    logic [2:0]    r_status, n_status;
    logic [RW-1:0] r_hold, n_hold;
    t_result       r_res, n_res;
    logic          r_ov, n_ov;

    logic          rd_free;
    logic [ID_BITS-1:0] rd_own;
    logic [31:0]   rd_len;
    logic          accept;
    logic          cfg_wr;

    assign rd_free = r_rd[RW-1];
    assign rd_own  = r_rd[RW-2 -: ID_BITS];
    assign rd_len  = r_rd[31:0];

    // a pending capacity write wins over a new item
    assign s_axis_tready = (r_state == S_IDLE) && !r_ov && !r_boot && !i_cfg_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_ov && !r_boot;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_res.full_flag, r_res.seg_total, r_res.rd_size,
                            r_res.rd_id, r_res.rd_free, r_res.status};

    // memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    function automatic logic [RW-1:0] pack(input logic f, input logic [ID_BITS-1:0] o,
                                            input logic [31:0] l);
        return {f, o, l};
    endfunction

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_full = r_full; n_i = r_i; n_w = r_w;
        n_pos = r_pos; n_rv = 1'b0; n_acc = r_acc; n_any = r_any; n_retry = r_retry;
        n_phase = r_phase; n_status = r_status; n_hold = r_hold; n_res = r_res;
        n_ov = r_ov;
        rd_addr = r_i[AW-1:0]; wr_addr = r_pos; wr_data = r_hold; wr_en = 1'b0;
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end
        if (r_boot) begin
            wr_en = 1'b1; wr_addr = '0;
            wr_data = pack(1'b1, '0, CAP_RESET);
        end
        if (cfg_wr) begin
            wr_en = 1'b1; wr_addr = '0;
            wr_data = pack(1'b1, '0, i_cfg_data);
            n_cnt = CW'(1); n_full = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_i = '0; n_rv = 1'b0; n_status = ST_OK; n_retry = 1'b0;
                    n_res = '0;
                    if (r_full) begin
                        n_status = ST_IGNORED; n_state = S_DONE;
                    end else begin
                        unique case (s_axis_tdata[1:0])
                            REQ_INSERT:  n_state = S_FIND;
                            REQ_REMOVE:  n_state = S_RFIND;
                            REQ_COMPACT: begin
                                n_state = S_CMP; n_w = '0; n_acc = '0; n_any = 1'b0;
                            end
                            default:     n_state = S_READ;
                        endcase
                    end
                end
            end
            // issue read at r_i, check r_rd for r_i-1
            S_FIND: begin
                if (r_rv && rd_free && rd_len >= r_size) begin
                    n_pos = AW'(r_i - CW'(1));
                    if (rd_len == r_size) begin
                        wr_en = 1'b1; wr_addr = AW'(r_i - CW'(1));
                        wr_data = pack(1'b0, r_id, rd_len);
                        n_state = S_DONE;
                    end else if (r_cnt >= CW'(MAX_SEGMENTS)) begin
                        // no room for the split: same as no fit
                        n_i = '0;
                        if (r_retry) begin
                            n_full = 1'b1; n_status = ST_NO_SPACE; n_state = S_DONE;
                        end else begin
                            n_state = S_CMP; n_w = '0; n_acc = '0; n_any = 1'b0;
                        end
                    end else begin
                        n_acc = rd_len - r_size;
                        n_i = r_cnt; n_state = S_SHIFT;
                    end
                end else if (r_i < r_cnt) begin
                    n_i = r_i + CW'(1); n_rv = 1'b1;
                end else if (r_rv || r_cnt == '0) begin
                    n_i = '0;
                    if (r_retry) begin
                        n_full = 1'b1; n_status = ST_NO_SPACE; n_state = S_DONE;
                    end else begin
                        n_state = S_CMP; n_w = '0; n_acc = '0; n_any = 1'b0;
                    end
                end else begin
                    n_i = '0;
                end
            end
            // move entries up: k from count down to pos+2, mem[k]=mem[k-1]; pos+1 gets the free remainder
            S_SHIFT: begin
                if (r_phase == 2'd0) begin
                    rd_addr = AW'(r_i - CW'(1)); n_phase = 2'd1;
                end else begin
                    wr_en = 1'b1; wr_addr = r_i[AW-1:0]; wr_data = r_rd;
                    if (AW'(r_i - CW'(1)) == r_pos) begin
                        wr_data = pack(1'b1, '0, r_acc);
                        n_state = S_PLACE;
                    end else begin
                        n_i = r_i - CW'(1);
                    end
                    n_phase = 2'd0;
                end
            end
            S_PLACE: begin
                wr_en = 1'b1; wr_addr = r_pos; wr_data = pack(1'b0, r_id, r_size);
                n_cnt = r_cnt + CW'(1); n_state = S_DONE;
            end
            // stable compaction: read r_i, write allocated at r_w
            S_CMP: begin
                if (r_rv) begin
                    if (rd_free) begin
                        n_acc = sat_add(r_acc, rd_len); n_any = 1'b1;
                    end else begin
                        wr_en = 1'b1; wr_addr = r_w[AW-1:0]; wr_data = r_rd;
                        n_w = r_w + CW'(1);
                    end
                end
                if (r_i < r_cnt && !(r_rv && r_i == '0)) begin
                    n_i = r_i + CW'(1); n_rv = 1'b1;
                end else if (r_rv || r_cnt == '0) begin
                    n_state = S_CTAIL;
                end else begin
                    n_i = '0;
                end
                if (r_i == '0 && !r_rv && r_cnt != '0) begin
                    n_i = CW'(1); n_rv = 1'b1;
                end
            end
            S_CTAIL: begin
                if (r_any && r_w < CW'(MAX_SEGMENTS)) begin
                    wr_en = 1'b1; wr_addr = r_w[AW-1:0]; wr_data = pack(1'b1, '0, r_acc);
                    n_cnt = r_w + CW'(1);
                end else begin
                    n_cnt = r_w;
                end
                n_i = '0;
                if (r_req == REQ_INSERT && !r_retry) begin
                    n_retry = 1'b1; n_state = S_FIND;
                end else begin
                    n_state = S_DONE;
                end
            end
            // remove: find first allocated with id
            S_RFIND: begin
                if (r_rv && !rd_free && rd_own == r_id) begin
                    n_pos = AW'(r_i - CW'(1)); n_hold = r_rd; n_phase = 2'd0;
                    n_state = S_RMRG;
                end else if (r_i < r_cnt) begin
                    n_i = r_i + CW'(1); n_rv = 1'b1;
                end else if (r_rv || r_cnt == '0) begin
                    n_status = ST_NOT_FND; n_state = S_DONE;
                end else begin
                    n_i = '0;
                end
            end
            // phase 0: read left; 1: decide left; 2: read right wait; 3: decide right
            S_RMRG: begin
                unique case (r_phase)
                    2'd0: begin
                        rd_addr = AW'(r_pos - AW'(1)); n_phase = 2'd1;
                        n_hold = pack(1'b1, '0, r_hold[31:0]);
                    end
                    2'd1: begin
                        if (r_pos != '0 && rd_free) begin
                            wr_en = 1'b1; wr_addr = AW'(r_pos - AW'(1));
                            n_hold = pack(1'b1, '0, sat_add(rd_len, r_hold[31:0]));
                            wr_data = n_hold;
                            n_i = CW'(r_pos); n_pos = AW'(r_pos - AW'(1));
                            n_w = CW'(1); n_state = S_DEL; n_phase = 2'd0;
                        end else begin
                            wr_en = 1'b1; wr_addr = r_pos; wr_data = r_hold;
                            n_phase = 2'd2;
                        end
                    end
                    2'd2: begin
                        rd_addr = AW'(r_pos + AW'(1)); n_phase = 2'd3;
                    end
                    default: begin
                        if (CW'(r_pos) + CW'(1) < r_cnt && rd_free) begin
                            wr_en = 1'b1; wr_addr = r_pos;
                            wr_data = pack(1'b1, '0, sat_add(r_hold[31:0], rd_len));
                            n_i = CW'(r_pos) + CW'(1); n_w = CW'(0);
                            n_state = S_DEL; n_phase = 2'd0;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            // delete entry r_i: mem[k]=mem[k+1] for k=r_i..cnt-2
            S_DEL: begin
                if (r_i + CW'(1) >= r_cnt) begin
                    n_cnt = r_cnt - CW'(1);
                    n_state = S_RDEL2;
                end else if (r_phase == 2'd0) begin
                    rd_addr = AW'(r_i + CW'(1)); n_phase = 2'd1;
                end else begin
                    wr_en = 1'b1; wr_addr = r_i[AW-1:0]; wr_data = r_rd;
                    n_i = r_i + CW'(1); n_phase = 2'd0;
                end
            end
            // after left merge, check right neighbor; else finish
            S_RDEL2: begin
                if (r_w == CW'(1)) begin
                    n_w = '0; n_phase = 2'd2; n_state = S_RMRG;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (r_phase == 2'd0) begin
                    rd_addr = r_idx[AW-1:0]; n_phase = 2'd1;
                end else begin
                    n_phase = 2'd0;
                    if (CW'(r_idx) < r_cnt && 7'(r_idx) < 7'(MAX_SEGMENTS)) begin
                        n_res.rd_free = rd_free;
                        n_res.rd_id   = rd_free ? 16'd0 : 16'(rd_own);
                        n_res.rd_size = rd_len;
                    end else begin
                        n_status = ST_BAD_IDX;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_res.status = r_status; n_res.seg_total = 7'(r_cnt);
                    n_res.full_flag = r_full; n_ov = 1'b1; n_state = S_IDLE;
                    n_phase = 2'd0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= CW'(1); r_full <= 1'b0; r_ov <= 1'b0;
            r_phase <= 2'd0; r_rv <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_full <= n_full; r_ov <= n_ov;
            r_phase <= n_phase; r_rv <= n_rv;
        end
        r_i <= n_i; r_w <= n_w; r_pos <= n_pos; r_acc <= n_acc; r_any <= n_any;
        r_retry <= n_retry; r_status <= n_status; r_hold <= n_hold; r_res <= n_res;
        if (accept) begin
            r_req  <= s_axis_tdata[1:0];
            r_id   <= ID_BITS'(s_axis_tdata[17:2]);
            r_size <= s_axis_tdata[49:18];
            r_idx  <= s_axis_tdata[55:50];
        end
    end

    // boot cycle after reset writes the reset capacity segment into entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 1'b1;
        else          r_boot <= 1'b0;
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready) else $error("accepted while busy");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !cfg_wr) |=> r_full) else $error("full flag dropped");
`endif
endmodule
